@@ src/pst_pkg.sv @@
// Package for the priority schedule timing block: types, widths and controller states.
package pst_pkg;

    localparam int MAX_JOBS_DEF = 32;
    localparam int PRI_W        = 16;
    localparam int BURST_W      = 16;
    localparam int ID_W         = 6;
    localparam int TIME_W       = 21;
    localparam int TOT_W        = 27;
    localparam int AVG_W        = 29;
    localparam int FRAC_W       = 8;
    localparam int DIVD_W       = TOT_W + FRAC_W;
    localparam int DCNT_W       = $clog2(DIVD_W);

    typedef struct packed {
        logic [PRI_W-1:0]   pri;
        logic [BURST_W-1:0] burst;
        logic [ID_W-1:0]    id;
    } t_job;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SRD,
        S_SCMP,
        S_WA,
        S_WS,
        S_TRD,
        S_TACC,
        S_DINIT,
        S_DIV,
        S_ERD,
        S_ELD,
        S_EOUT
    } t_state;

    typedef struct packed {
        logic load;
        logic last_in;
        logic scan_cmp;
        logic wr_a;
        logic wr_sel;
        logic tot_acc;
        logic div_init;
        logic div_step;
        logic emit_load;
        logic emit_next;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic pos_end;
        logic div_done;
    } t_status;

endpackage

@@ src/pst_ctrl.sv @@
// Controller state machine for the priority schedule timing block.
module pst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_last_job,
    input  logic             i_ready,
    input  pst_pkg::t_status i_status,
    output logic             o_ready,
    output logic             o_valid,
    output pst_pkg::t_cmd    o_cmd
);
    import pst_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_valid && i_last_job) n_state = S_SRD;
            end
            S_SRD:   n_state = S_SCMP;
            S_SCMP:  n_state = i_status.scan_end ? S_WA : S_SRD;
            S_WA:    n_state = S_WS;
            S_WS:    n_state = i_status.pos_end ? S_TRD : S_SRD;
            S_TRD:   n_state = S_TACC;
            S_TACC:  n_state = i_status.scan_end ? S_DINIT : S_TRD;
            S_DINIT: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) n_state = S_ERD;
            end
            S_ERD:   n_state = S_ELD;
            S_ELD:   n_state = S_EOUT;
            S_EOUT: begin
                if (i_ready) n_state = i_status.scan_end ? S_LOAD : S_ERD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_ready         = (r_state == S_LOAD);
        o_valid         = (r_state == S_EOUT);
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_LOAD) && i_valid;
        o_cmd.last_in   = i_last_job;
        o_cmd.scan_cmp  = (r_state == S_SCMP);
        o_cmd.wr_a      = (r_state == S_WA);
        o_cmd.wr_sel    = (r_state == S_WS);
        o_cmd.tot_acc   = (r_state == S_TACC);
        o_cmd.div_init  = (r_state == S_DINIT);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.emit_load = (r_state == S_ELD);
        o_cmd.emit_next = (r_state == S_EOUT) && i_ready;
    end

endmodule

@@ src/pst_dp.sv @@
// Datapath: job memory, selection sort scan, totals, average dividers and result registers.
module pst_dp #(
    parameter int MAX_JOBS = pst_pkg::MAX_JOBS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pst_pkg::t_cmd                i_cmd,
    input  logic [pst_pkg::BURST_W-1:0]  i_burst_time,
    input  logic [pst_pkg::PRI_W-1:0]    i_priority_req,
    output pst_pkg::t_status             o_status,
    output logic [pst_pkg::ID_W-1:0]     o_job_number,
    output logic [pst_pkg::BURST_W-1:0]  o_burst_out,
    output logic [pst_pkg::TIME_W-1:0]   o_waiting_time,
    output logic [pst_pkg::TIME_W-1:0]   o_turnaround_time,
    output logic [pst_pkg::AVG_W-1:0]    o_avg_waiting,
    output logic [pst_pkg::AVG_W-1:0]    o_avg_turnaround,
    output logic                         o_last_result
);
    import pst_pkg::*;

    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    t_job mem [MAX_JOBS];

    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_a;
    logic [IW-1:0]     r_b;
    logic [IW-1:0]     r_sel;
    t_job              r_min;
    t_job              r_olda;
    t_job              r_rd;
    logic [TOT_W-1:0]  r_elapsed;
    logic [TOT_W-1:0]  r_wt_tot;
    logic [TOT_W-1:0]  r_tat_tot;
    logic [DIVD_W-1:0] r_qw;
    logic [DIVD_W-1:0] r_qt;
    logic [CW:0]       r_remw;
    logic [CW:0]       r_remt;
    logic [DCNT_W-1:0] r_dcnt;

    logic              full;
    logic [CW-1:0]     last_idx;
    logic              we;
    logic [IW-1:0]     waddr;
    t_job              wdata;
    t_job              new_job;
    logic [TOT_W-1:0]  tat;
    logic [CW:0]       rw2;
    logic [CW:0]       rt2;
    logic              gew;
    logic              get;
    logic [CW:0]       divisor;

    assign full     = (r_count == CW'(MAX_JOBS));
    assign last_idx = r_count - CW'(1);
    assign o_status.scan_end = (CW'(r_b) == last_idx);
    assign o_status.pos_end  = (CW'(r_a) == last_idx);
    assign o_status.div_done = (r_dcnt == DCNT_W'(DIVD_W - 1));

    assign new_job.pri   = i_priority_req;
    assign new_job.burst = i_burst_time;
    assign new_job.id    = ID_W'(r_count + CW'(1));

    assign tat     = r_elapsed + TOT_W'(r_rd.burst);
    assign divisor = {1'b0, r_count};
    assign rw2     = {r_remw[CW-1:0], r_qw[DIVD_W-1]};
    assign rt2     = {r_remt[CW-1:0], r_qt[DIVD_W-1]};
    assign gew     = (rw2 >= divisor);
    assign get     = (rt2 >= divisor);

    always_comb begin
        we    = 1'b0;
        waddr = r_a;
        wdata = r_min;
        if (i_cmd.load && !full) begin
            we    = 1'b1;
            waddr = r_count[IW-1:0];
            wdata = new_job;
        end else if (i_cmd.wr_a) begin
            we    = 1'b1;
        end else if (i_cmd.wr_sel) begin
            we    = 1'b1;
            waddr = r_sel;
            wdata = r_olda;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[r_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_dcnt  <= '0;
        end else begin
            if (i_cmd.load) begin
                if (!full) r_count <= r_count + CW'(1);
                if (i_cmd.last_in) begin
                    r_a <= '0;
                    r_b <= '0;
                end
            end
            if (i_cmd.scan_cmp) r_b <= r_b + IW'(1);
            if (i_cmd.wr_sel) begin
                if (o_status.pos_end) begin
                    r_b <= '0;
                end else begin
                    r_a <= r_a + IW'(1);
                    r_b <= r_a + IW'(1);
                end
            end
            if (i_cmd.tot_acc) r_b <= r_b + IW'(1);
            if (i_cmd.div_init) begin
                r_b    <= '0;
                r_dcnt <= '0;
            end
            if (i_cmd.div_step) r_dcnt <= r_dcnt + DCNT_W'(1);
            if (i_cmd.emit_next) begin
                if (o_last_result) r_count <= '0;
                else r_b <= r_b + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_cmp) begin
            if (r_b == r_a) begin
                r_min  <= r_rd;
                r_olda <= r_rd;
                r_sel  <= r_a;
            end else if (r_rd.pri < r_min.pri) begin
                r_min <= r_rd;
                r_sel <= r_b;
            end
        end
        if (i_cmd.wr_sel && o_status.pos_end) begin
            r_elapsed <= '0;
            r_wt_tot  <= '0;
            r_tat_tot <= '0;
        end
        if (i_cmd.tot_acc) begin
            r_wt_tot  <= r_wt_tot + r_elapsed;
            r_tat_tot <= r_tat_tot + tat;
            r_elapsed <= tat;
        end
        if (i_cmd.div_init) begin
            r_qw      <= {r_wt_tot, FRAC_W'(0)};
            r_qt      <= {r_tat_tot, FRAC_W'(0)};
            r_remw    <= '0;
            r_remt    <= '0;
            r_elapsed <= '0;
        end
        if (i_cmd.div_step) begin
            r_remw <= gew ? rw2 - divisor : rw2;
            r_remt <= get ? rt2 - divisor : rt2;
            r_qw   <= {r_qw[DIVD_W-2:0], gew};
            r_qt   <= {r_qt[DIVD_W-2:0], get};
        end
        if (i_cmd.emit_load) begin
            o_job_number      <= r_rd.id;
            o_burst_out       <= r_rd.burst;
            o_waiting_time    <= r_elapsed[TIME_W-1:0];
            o_turnaround_time <= tat[TIME_W-1:0];
            o_last_result     <= o_status.scan_end;
            o_avg_waiting     <= o_status.scan_end ? r_qw[AVG_W-1:0] : '0;
            o_avg_turnaround  <= o_status.scan_end ? r_qt[AVG_W-1:0] : '0;
            r_elapsed         <= tat;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_JOBS))
        else $error("job count beyond capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_cmp |-> (r_b >= r_a))
        else $error("scan index below sort position");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_load |-> (r_count != '0))
        else $error("emission with empty job set");

endmodule

@@ src/priority_schedule_timing.sv @@
// Top level of the non-preemptive priority schedule timing block.
// Jobs load at one transaction per cycle while the input is ready. After the transaction
// with last_job set, the block sorts the n held jobs with a selection sort over its job
// memory (one read port, one write port), then sums the times and runs the two
// shift-subtract dividers of the averages. Input is not accepted until the last result
// of the set has been taken. Jobs beyond MAX_JOBS are dropped.
module priority_schedule_timing #(
    parameter int MAX_JOBS = pst_pkg::MAX_JOBS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pst_pkg::BURST_W-1:0]  i_burst_time,
    input  logic [pst_pkg::PRI_W-1:0]    i_priority_req,
    input  logic                         i_last_job,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pst_pkg::ID_W-1:0]     o_job_number,
    output logic [pst_pkg::BURST_W-1:0]  o_burst_out,
    output logic [pst_pkg::TIME_W-1:0]   o_waiting_time,
    output logic [pst_pkg::TIME_W-1:0]   o_turnaround_time,
    output logic [pst_pkg::AVG_W-1:0]    o_avg_waiting,
    output logic [pst_pkg::AVG_W-1:0]    o_avg_turnaround,
    output logic                         o_last_result
);
    import pst_pkg::*;

    t_cmd    cmd;
    t_status status;

    pst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_last_job (i_last_job),
        .i_ready    (i_ready),
        .i_status   (status),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .o_cmd      (cmd)
    );

    pst_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_burst_time      (i_burst_time),
        .i_priority_req    (i_priority_req),
        .o_status          (status),
        .o_job_number      (o_job_number),
        .o_burst_out       (o_burst_out),
        .o_waiting_time    (o_waiting_time),
        .o_turnaround_time (o_turnaround_time),
        .o_avg_waiting     (o_avg_waiting),
        .o_avg_turnaround  (o_avg_turnaround),
        .o_last_result     (o_last_result)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_turnaround_time == TIME_W'(o_waiting_time + TIME_W'(o_burst_out))))
        else $error("turnaround differs from waiting plus burst");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_result) |-> (o_avg_waiting == '0 && o_avg_turnaround == '0))
        else $error("average shown on a result that is not the last");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("loading while results are pending");

endmodule
